// File: design/est_pkg.sv
// Shared types and constants for the enveloped sine trajectory core.
package est_pkg;
	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_RUN  = 2'd1;
	localparam logic [1:0] MODE_DONE = 2'd2;

	localparam logic [2:0] REG_AMP     = 3'd0;
	localparam logic [2:0] REG_FSTEP   = 3'd1;
	localparam logic [2:0] REG_CYC     = 3'd2;
	localparam logic [2:0] REG_MAXAMP  = 3'd3;
	localparam logic [2:0] REG_MINFS   = 3'd4;
	localparam logic [2:0] REG_MAXFS   = 3'd5;
	localparam logic [2:0] REG_MAXCYC  = 3'd6;

	localparam logic [31:0] COEF_A = 32'd102944;
	localparam logic [31:0] COEF_B = 32'd42048;
	localparam logic [31:0] COEF_C = 32'd4640;

	typedef logic [15:0] q15_t;
endpackage

// File: design/enveloped_sine_trajectory_core.sv
// Top level of the enveloped sine trajectory core.
//
// Usage: one input transaction per control tick (enable, wheel_position);
// exactly one output transaction (run_state, angle_command) follows it.
// A rising enable latches amplitude, frequency step and cycle count, each
// clamped to its limit registers, plus the wheel position, and starts the
// trajectory. While running, the command is start position plus amplitude
// times a triangular envelope times a quarter-wave polynomial sine of phase.
// Once the phase passes the cycle count the core reports done and follows
// the wheel position, as it does when idle or disabled.
// A running tick goes through a bit-serial restoring divider for the
// envelope, four shift-add multiplies for the sine value, the clamp of
// that value, two more shift-add multiplies for env*amp*sine and the
// final add, in that order, before out_valid rises. Idle and done ticks
// skip all of that, and out_valid rises in the cycle after the input
// transaction. Only one item is in work at a time; in_ready is low
// until its result has been taken and returns in the cycle after that.
// A stalled receiver holds the result in the output register.
// Reset clears sequencer and trajectory state and restores register defaults.
// Configuration goes through an APB-style port; pready is always high.
module enveloped_sine_trajectory_core #(
	parameter int SINE_TABLE_DEPTH    = 256,
	parameter int PHASE_FRACTION_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        enable,
	input  logic signed [16:0] wheel_position,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  run_state,
	output logic signed [17:0] angle_command,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import est_pkg::*;

	localparam int PW = PHASE_FRACTION_BITS + 9; // phase accumulator width
	localparam int DB = $clog2(SINE_TABLE_DEPTH);
	localparam int CW = PHASE_FRACTION_BITS + 10; // width of 2C

	// sequencer states
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DIV  = 4'd1;
	localparam logic [3:0] ST_X2   = 4'd2;
	localparam logic [3:0] ST_M1   = 4'd3;
	localparam logic [3:0] ST_M2   = 4'd4;
	localparam logic [3:0] ST_M3   = 4'd5;
	localparam logic [3:0] ST_M4   = 4'd6;
	localparam logic [3:0] ST_EA   = 4'd7;
	localparam logic [3:0] ST_ES   = 4'd8;
	localparam logic [3:0] ST_FIN  = 4'd9;
	localparam logic [3:0] ST_OUT  = 4'd10;

	// configuration registers
	logic [15:0] amp_q, maxamp_q;
	logic [22:0] fstep_q, minfs_q, maxfs_q;
	logic [7:0]  cyc_q, maxcyc_q;
	logic [2:0]  reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q    <= '0;
			fstep_q  <= '0;
			cyc_q    <= '0;
			maxamp_q <= 16'hFFFF;
			minfs_q  <= 23'd1;
			maxfs_q  <= 23'h7FFFFF;
			maxcyc_q <= 8'hFF;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_AMP:    amp_q    <= pwdata[15:0];
				REG_FSTEP:  fstep_q  <= pwdata[22:0];
				REG_CYC:    cyc_q    <= pwdata[7:0];
				REG_MAXAMP: maxamp_q <= pwdata[15:0];
				REG_MINFS:  minfs_q  <= pwdata[22:0];
				REG_MAXFS:  maxfs_q  <= pwdata[22:0];
				REG_MAXCYC: maxcyc_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_AMP:    prdata = {16'd0, amp_q};
			REG_FSTEP:  prdata = {9'd0, fstep_q};
			REG_CYC:    prdata = {24'd0, cyc_q};
			REG_MAXAMP: prdata = {16'd0, maxamp_q};
			REG_MINFS:  prdata = {9'd0, minfs_q};
			REG_MAXFS:  prdata = {9'd0, maxfs_q};
			REG_MAXCYC: prdata = {24'd0, maxcyc_q};
			default:    prdata = '0;
		endcase
	end

	// trajectory state
	logic        prev_en_q;
	logic [1:0]  mode_q;
	logic [PW-1:0] phase_q;
	logic [15:0] hamp_q;
	logic [22:0] hstep_q;
	logic [7:0]  hcyc_q;
	logic signed [16:0] start_q;

	logic [3:0]  st_q;
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic [1:0]  next_q;

	// serial divider / multiplier registers
	logic [CW+17:0] rem_q;   // remainder shift register
	logic [16:0]    quo_q;   // envelope quotient, 0..65536
	logic [49:0]    acc_q;   // shift-add accumulator
	logic [49:0]    mcand_q; // multiplicand
	logic [33:0]    mplier_q;// multiplier, shifted out one bit a cycle
	logic [31:0]    x_q, x2_q;
	logic [15:0]    s_q;

	// clamp at latch time
	logic [15:0] amp_c;
	logic [22:0] fs_c, fs_hi;
	logic [7:0]  cyc_c, cyc_hi;
	always_comb begin
		amp_c  = (amp_q > maxamp_q) ? maxamp_q : amp_q;
		fs_hi  = (fstep_q > maxfs_q) ? maxfs_q : fstep_q;
		fs_c   = (fs_hi < minfs_q) ? minfs_q : fs_hi;
		cyc_hi = (cyc_q > maxcyc_q) ? maxcyc_q : cyc_q;
		cyc_c  = (cyc_hi < 8'd1) ? 8'd1 : cyc_hi;
	end

	// phase decomposition
	logic [CW-1:0] c_w, p2_w, num_w;
	logic [PHASE_FRACTION_BITS-1:0] frac_w;
	logic [DB+1:0] idx_w;
	logic [DB:0]   k_w;
	always_comb begin
		c_w    = CW'(hcyc_q) << PHASE_FRACTION_BITS;
		p2_w   = CW'(phase_q) << 1;
		num_w  = (p2_w < c_w) ? p2_w : ((c_w << 1) - p2_w);
		frac_w = phase_q[PHASE_FRACTION_BITS-1:0];
		idx_w  = frac_w[PHASE_FRACTION_BITS-1 -: (DB+2)];
		k_w    = idx_w[DB] ? ((DB+1)'(SINE_TABLE_DEPTH) - {1'b0, idx_w[DB-1:0]})
		                   : {1'b0, idx_w[DB-1:0]};
	end

	// one shift-add step
	logic [49:0] acc_nx;
	assign acc_nx = mplier_q[0] ? acc_q + mcand_q : acc_q;

	// divider step: compare shifted remainder against divisor
	logic [CW:0]   rtop;
	logic [CW+17:0] rsh;
	assign rsh  = rem_q << 1;
	assign rtop = rsh[CW+17:17];

	logic [CW:0] nphase;
	assign nphase = (CW+1)'(phase_q) + (CW+1)'(hstep_q);

	logic [31:0] y_w;
	assign y_w = (acc_q[47:16] + 32'd1) >> 1;

	logic signed [17:0] ang_w;
	logic [17:0] mag_w;
	assign mag_w = 18'((acc_q + 50'h40000000) >> 31);
	assign ang_w = neg_q ? (18'(start_q) - $signed(mag_w)) : (18'(start_q) + $signed(mag_w));

	logic signed [17:0] ang_q;
	logic acc_in;
	assign in_ready  = (st_q == ST_IDLE);
	assign acc_in    = in_valid && in_ready;
	assign out_valid = (st_q == ST_OUT);
	assign run_state = next_q;
	assign angle_command = ang_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			prev_en_q <= 1'b0;
			mode_q    <= MODE_IDLE;
			phase_q   <= '0;
			hamp_q    <= '0;
			hstep_q   <= '0;
			hcyc_q    <= '0;
			start_q   <= '0;
			next_q    <= MODE_IDLE;
			cnt_q     <= '0;
		end else begin
			case (st_q)
				ST_IDLE: if (acc_in) begin
					prev_en_q <= enable;
					if (!prev_en_q && enable) begin
						hamp_q  <= amp_c;
						hstep_q <= fs_c;
						hcyc_q  <= cyc_c;
						start_q <= wheel_position;
					end
					if (enable && mode_q == MODE_RUN) begin
						rem_q <= (CW+18)'(num_w) << 16 >> 0;
						quo_q <= '0;
						cnt_q <= 6'd0;
						st_q  <= ST_DIV;
					end else begin
						phase_q <= '0;
						next_q  <= (enable && mode_q == MODE_DONE) ? MODE_DONE
						         : (enable ? MODE_RUN : MODE_IDLE);
						mode_q  <= (enable && mode_q == MODE_DONE) ? MODE_DONE
						         : (enable ? MODE_RUN : MODE_IDLE);
						ang_q   <= 18'(wheel_position);
						st_q    <= ST_OUT;
					end
				end
				ST_DIV: begin
					// restoring division of num*2^16 by C, one bit per cycle
					if (rtop >= (CW+1)'(c_w)) begin
						rem_q <= {rtop - (CW+1)'(c_w), rsh[16:0]};
						quo_q <= {quo_q[15:0], 1'b1};
					end else begin
						rem_q <= rsh;
						quo_q <= {quo_q[15:0], 1'b0};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd16) begin
						x_q      <= 32'(({16'd0, k_w} << 16) >> DB);
						neg_q    <= idx_w[DB+1];
						acc_q    <= '0;
						mcand_q  <= 50'(32'(({16'd0, k_w} << 16) >> DB));
						mplier_q <= 34'(32'(({16'd0, k_w} << 16) >> DB));
						cnt_q    <= '0;
						st_q     <= ST_X2;
					end
				end
				ST_X2, ST_M1, ST_M2, ST_M3, ST_EA, ST_ES: begin
					acc_q    <= acc_nx;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					cnt_q    <= cnt_q + 6'd1;
					if (cnt_q == 6'd33) begin
						cnt_q <= '0;
						acc_q <= '0;
						case (st_q)
							ST_X2: begin
								x2_q <= acc_nx[47:16];
								mcand_q <= 50'(COEF_C); mplier_q <= 34'(acc_nx[47:16]);
								st_q <= ST_M1;
							end
							ST_M1: begin
								mcand_q <= 50'(COEF_B - acc_nx[47:16]);
								mplier_q <= 34'(x2_q);
								st_q <= ST_M2;
							end
							ST_M2: begin
								mcand_q <= 50'(COEF_A - acc_nx[47:16]);
								mplier_q <= 34'(x_q);
								st_q <= ST_M3;
							end
							ST_M3: begin
								acc_q <= acc_nx;
								st_q  <= ST_M4;
							end
							ST_EA: begin
								mcand_q <= 50'(acc_nx[32:0]);
								mplier_q <= 34'(s_q);
								st_q <= ST_ES;
							end
							default: begin
								acc_q <= acc_nx;
								st_q  <= ST_FIN;
							end
						endcase
					end
				end
				ST_M4: begin
					s_q      <= (y_w > 32'd32767) ? 16'd32767 : y_w[15:0];
					acc_q    <= '0;
					mcand_q  <= 50'(quo_q);
					mplier_q <= 34'(hamp_q);
					st_q     <= ST_EA;
				end
				ST_FIN: begin
					ang_q   <= ang_w;
					phase_q <= nphase[PW-1:0];
					next_q  <= (nphase > (CW+1)'(c_w)) ? MODE_DONE : MODE_RUN;
					mode_q  <= (nphase > (CW+1)'(c_w)) ? MODE_DONE : MODE_RUN;
					st_q    <= ST_OUT;
				end
				ST_OUT: if (out_ready) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// the sine value never exceeds full scale
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EA) |-> (s_q <= 16'd32767))
		else $error("sine magnitude out of range");
	// no input is taken while a result is pending
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input accepted during output");
	// the envelope never exceeds unity
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_X2) |-> (quo_q <= 17'h10000))
		else $error("envelope out of range");
endmodule

// File: tb/sv/enveloped_sine_trajectory_core_tb.sv
// Self-checking testbench for the enveloped sine trajectory core.
`timescale 1ns / 1ps
module enveloped_sine_trajectory_core_tb;
	import est_pkg::*;

	localparam int DEPTH = 256;
	localparam int FRAC = 24;
	localparam longint LIMIT = 2000000;

	typedef struct packed {
		logic enable;
		logic signed [16:0] wheel_position;
	} tick_t;

	typedef struct packed {
		logic [1:0] run_state;
		logic signed [17:0] angle_command;
	} cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic enable = 1'b0;
	logic signed [16:0] wheel_position = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] run_state;
	logic signed [17:0] angle_command;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	enveloped_sine_trajectory_core dut (.*);

	always #5 clk = ~clk;

	// configuration shadow and predictor state
	logic [15:0] cfg_amp, cfg_maxamp;
	logic [22:0] cfg_fstep, cfg_minfs, cfg_maxfs;
	logic [7:0] cfg_cyc, cfg_maxcyc;
	logic prev_en;
	logic [1:0] traj_mode;
	logic [63:0] phase_acc;
	logic [15:0] hold_amp;
	logic [22:0] hold_step;
	logic [7:0] hold_cyc;
	logic signed [16:0] start_pos;

	tick_t tick_q[$];
	cmd_t cmd_q[$];
	int send_idle_pct, recv_idle_pct;
	int errors = 0;
	int checked = 0;
	int running_seen = 0;
	int done_seen = 0;
	longint cycles = 0;

	function automatic logic [63:0] quarter_wave(logic [63:0] k);
		logic [63:0] x, x2, t, y;
		if (k > DEPTH) k = DEPTH;
		x = (k << 16) / DEPTH;
		x2 = (x * x) >> 16;
		t = 64'd42048 - ((64'd4640 * x2) >> 16);
		t = 64'd102944 - ((t * x2) >> 16);
		y = ((t * x) >> 16);
		y = (y + 1) >> 1;
		return (y > 32767) ? 64'd32767 : y;
	endfunction

	function automatic logic signed [31:0] oscillation_angle();
		logic [63:0] c, p2, env, fr, idx, q, k, s, mag;
		c = 64'(hold_cyc) << FRAC;
		p2 = phase_acc << 1;
		if (p2 < c) env = (p2 << 16) / c;
		else env = (((c << 1) - p2) << 16) / c;
		fr = phase_acc & ((64'd1 << FRAC) - 1);
		idx = (fr * 4 * DEPTH) >> FRAC;
		q = (idx / DEPTH) & 3;
		k = idx % DEPTH;
		s = q[0] ? quarter_wave(DEPTH - k) : quarter_wave(k);
		mag = (env * hold_amp * s + (64'd1 << 30)) >> 31;
		return q >= 2 ? 32'(start_pos) - 32'(mag) : 32'(start_pos) + 32'(mag);
	endfunction

	// advance the trajectory by one tick and queue the expected command
	task automatic predict_tick(tick_t t);
		logic [1:0] cur, nxt;
		logic signed [31:0] ang;
		logic [22:0] st;
		if (!prev_en && t.enable) begin
			hold_amp = cfg_amp > cfg_maxamp ? cfg_maxamp : cfg_amp;
			st = cfg_fstep > cfg_maxfs ? cfg_maxfs : cfg_fstep;
			hold_step = st < cfg_minfs ? cfg_minfs : st;
			hold_cyc = cfg_cyc > cfg_maxcyc ? cfg_maxcyc : cfg_cyc;
			if (hold_cyc < 1) hold_cyc = 1;
			start_pos = t.wheel_position;
		end
		cur = t.enable ? traj_mode : MODE_IDLE;
		ang = 32'(t.wheel_position);
		if (cur == MODE_RUN) begin
			ang = oscillation_angle();
			phase_acc += hold_step;
			nxt = (phase_acc > (64'(hold_cyc) << FRAC)) ? MODE_DONE : MODE_RUN;
		end else if (cur == MODE_DONE) begin
			nxt = MODE_DONE;
			phase_acc = 0;
		end else begin
			nxt = t.enable ? MODE_RUN : MODE_IDLE;
			phase_acc = 0;
		end
		prev_en = t.enable;
		traj_mode = nxt;
		cmd_q.push_back('{run_state: nxt, angle_command: ang[17:0]});
	endtask

	// driver: one transaction per handshake, new payload at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				// accepted at the last rising edge; nothing more to do
			end
		end
	end

	logic taken;
	always @(posedge clk) taken <= in_valid && in_ready;

	always @(negedge clk) begin
		if (arst_n && (!in_valid || taken)) begin
			if (tick_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				tick_t t;
				t = tick_q.pop_front();
				predict_tick(t);
				enable <= t.enable;
				wheel_position <= t.wheel_position;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	// monitor: compare each output transaction with the oldest expectation
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (out_valid && out_ready) begin
			if (cmd_q.size() == 0) begin
				$error("unexpected transaction: run_state %0d angle_command %0d",
					run_state, angle_command);
				errors = errors + 1;
			end else begin
				cmd_t e;
				e = cmd_q.pop_front();
				checked <= checked + 1;
				if (e.run_state == MODE_RUN) running_seen <= running_seen + 1;
				if (e.run_state == MODE_DONE) done_seen <= done_seen + 1;
				if (run_state !== e.run_state) begin
					$error("run_state expected %0d actual %0d", e.run_state, run_state);
					errors = errors + 1;
				end
				if (angle_command !== e.angle_command) begin
					$error("angle_command expected %0d actual %0d",
						e.angle_command, angle_command);
					errors = errors + 1;
				end
			end
		end
		if (cycles == LIMIT) begin
			$display("enveloped_sine_trajectory_core_tb: FAIL");
			$finish;
		end
	end

	task automatic apb_write(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_AMP: cfg_amp = val[15:0];
			REG_FSTEP: cfg_fstep = val[22:0];
			REG_CYC: cfg_cyc = val[7:0];
			REG_MAXAMP: cfg_maxamp = val[15:0];
			REG_MINFS: cfg_minfs = val[22:0];
			REG_MAXFS: cfg_maxfs = val[22:0];
			default: cfg_maxcyc = val[7:0];
		endcase
	endtask

	task automatic settle();
		wait (tick_q.size() == 0 && !in_valid);
		wait (cmd_q.size() == 0);
		repeat (100) @(negedge clk);
	endtask

	task automatic program_all(logic [15:0] a, logic [22:0] f, logic [7:0] c,
			logic [15:0] ma, logic [22:0] mnf, logic [22:0] mxf, logic [7:0] mc);
		apb_write(REG_AMP, 32'(a));
		apb_write(REG_FSTEP, 32'(f));
		apb_write(REG_CYC, 32'(c));
		apb_write(REG_MAXAMP, 32'(ma));
		apb_write(REG_MINFS, 32'(mnf));
		apb_write(REG_MAXFS, 32'(mxf));
		apb_write(REG_MAXCYC, 32'(mc));
	endtask

	// one trajectory: a disabled tick, then the rising edge and a run of enabled ticks
	task automatic queue_burst(int len);
		tick_t t;
		t.enable = 1'b0; t.wheel_position = 17'($urandom);
		tick_q.push_back(t);
		for (int i = 0; i < len; i++) begin
			t.enable = 1'b1;
			t.wheel_position = ($urandom_range(3) == 0) ? 17'($urandom)
				: 17'(int'($urandom_range(4000)) - 2000);
			tick_q.push_back(t);
		end
	endtask

	initial begin
		tick_t t;
		cfg_amp = 0; cfg_fstep = 0; cfg_cyc = 0; cfg_maxamp = 16'hFFFF;
		cfg_minfs = 1; cfg_maxfs = 23'h7FFFFF; cfg_maxcyc = 8'hFF;
		prev_en = 0; traj_mode = MODE_IDLE; phase_acc = 0;
		hold_amp = 0; hold_step = 0; hold_cyc = 0; start_pos = 0;
		send_idle_pct = 38; recv_idle_pct = 56;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed: reset clamps, wheel extremes, fast full-amplitude run to done
		program_all(16'hFFFF, 23'h7FFFFF, 8'd1, 16'hFFFF, 23'd1, 23'h7FFFFF, 8'd1);
		t = '{1'b0, 17'sh10000}; tick_q.push_back(t);
		t = '{1'b1, 17'sh0FFFF}; tick_q.push_back(t);
		for (int i = 0; i < 6; i++) begin
			t = '{1'b1, 17'sh10000}; tick_q.push_back(t);
		end
		t = '{1'b0, 17'sh0FFFF}; tick_q.push_back(t);
		settle();
		// crossed limits: lower limits win; zero step stalls at phase zero
		program_all(16'd500, 23'd0, 8'd0, 16'd0, 23'd0, 23'd0, 8'd3);
		queue_burst(5);
		settle();
		program_all(16'd40000, 23'd611393, 8'd200, 16'd30000,
			23'd900000, 23'd100, 8'd2);
		queue_burst(10);
		settle();

		// random phases with differing settings and idling patterns
		for (int ph = 0; ph < 12; ph++) begin
			if (ph == 4) begin send_idle_pct = 56; recv_idle_pct = 38; end
			if (ph == 8) begin send_idle_pct = 0; recv_idle_pct = 0; end
			program_all(16'($urandom), 23'($urandom_range(3000000, 200000)),
				8'($urandom_range(4)), ($urandom_range(3) == 0) ? 16'($urandom) : 16'hFFFF,
				23'($urandom_range(50000)), ($urandom_range(3) == 0) ? 23'($urandom)
				: 23'h7FFFFF, 8'($urandom_range(255, 1)));
			for (int b = 0; b < 4; b++) begin
				queue_burst($urandom_range(20, 5));
				if ($urandom_range(2) == 0) begin
					t.enable = 1'($urandom); t.wheel_position = 17'($urandom);
					tick_q.push_back(t);
				end
			end
			settle();
		end

		$display("checked %0d output transactions: %0d running, %0d done", checked,
			running_seen, done_seen);
		$display("covered directed extremes, crossed clamp limits, zero step, 12 random phases");
		if (errors == 0 && cmd_q.size() == 0) begin
			$display("enveloped_sine_trajectory_core_tb: PASS");
		end else begin
			$display("enveloped_sine_trajectory_core_tb: FAIL");
		end
		$finish;
	end
endmodule

// File: files.f
design/est_pkg.sv
design/enveloped_sine_trajectory_core.sv
tb/sv/enveloped_sine_trajectory_core_tb.sv
